// ===== sv/ser_pkg.sv =====
// Package with the shared types and constants of the session entry rate limiter.
`timescale 1ns / 1ps

package ser_pkg;

  // Table size default and field widths.
  localparam int unsigned TableEntriesDefault = 16;
  localparam int unsigned SidW                = 31;
  localparam int unsigned CountW              = 8;
  localparam int unsigned StampW              = 32;
  localparam int unsigned CfgIndexW           = 2;
  localparam int unsigned CfgDataW            = 16;
  localparam int unsigned SecondsPerMinute    = 60;

  // Item kinds.
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_MAX_ENTRIES = 2'd1,
    CFG_WINDOW      = 2'd2,
    CFG_EJECT_MIN   = 2'd3
  } cfg_index_t;

  // Register reset values.
  localparam logic [7:0]  MaxEntriesReset   = 8'd3;
  localparam logic [15:0] WindowReset       = 16'd10;
  localparam logic [9:0]  EjectMinutesReset = 10'd5;

  // Current configuration as seen by the engine.
  typedef struct packed {
    logic        enable;
    logic [7:0]  max_entries;
    logic [15:0] window_seconds;
    logic [9:0]  eject_minutes;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic            kind;
    logic [SidW-1:0] session_id;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic            eject;
    logic [SidW-1:0] eject_session;
    logic [15:0]     eject_seconds;
    logic            table_full;
  } out_item_t;

  // One slot of the session table as held in memory.
  typedef struct packed {
    logic [SidW-1:0]   session;
    logic [CountW-1:0] count;
    logic [StampW-1:0] start;
  } slot_t;

endpackage

// ===== sv/ser_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ser_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/ser_engine.sv =====
// Table sequencer: walks the session table in memory for entries and expiry sweeps.
`timescale 1ns / 1ps

module ser_engine #(
  parameter int unsigned TABLE_ENTRIES = ser_pkg::TableEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  ser_pkg::cfg_t       cfg,
  input  logic                start,
  input  ser_pkg::in_item_t   cmd,
  output logic                busy,
  output logic                result_valid,
  output ser_pkg::out_item_t  result
);

  import ser_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [CntW-1:0] NumSlots = CntW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t               state;
  logic [CntW-1:0]      issue_cnt;
  logic                 chk_vld;
  logic [IdxW-1:0]      chk_idx;
  logic [SidW-1:0]      sid;
  logic                 hit_found;
  logic [IdxW-1:0]      hit_idx;
  slot_t                hit_slot;
  logic                 free_found;
  logic [IdxW-1:0]      free_idx;
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [StampW-1:0]    seconds_now;

  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [$bits(slot_t)-1:0] rd_bits;
  slot_t                rd_slot;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  slot_t                wr_slot;
  logic [CountW-1:0]    cnt_inc;
  logic                 eject_hit;
  logic [15:0]          eject_secs;
  logic [StampW-1:0]    age;

  assign busy = (state != ST_IDLE);

  // Read issue: one slot per cycle while walking the table.
  assign rd_en   = ((state == ST_SCAN) || (state == ST_SWEEP)) && (issue_cnt < NumSlots);
  assign rd_addr = issue_cnt[IdxW-1:0];
  assign rd_slot = slot_t'(rd_bits);
  assign age     = seconds_now - rd_slot.start;

  // Update of the matched slot, saturating at the top of the count range.
  assign cnt_inc    = (hit_slot.count != {CountW{1'b1}}) ? hit_slot.count + CountW'(1)
                                                          : hit_slot.count;
  assign eject_hit  = (cnt_inc >= cfg.max_entries);
  assign eject_secs = {6'b0, cfg.eject_minutes} * 16'(SecondsPerMinute);

  // Write back either the matched slot or a new slot.
  assign wr_en   = (state == ST_UPDATE) && (hit_found || free_found);
  assign wr_addr = hit_found ? hit_idx : free_idx;
  always_comb begin
    if (hit_found) begin
      wr_slot = '{session: hit_slot.session, count: cnt_inc, start: hit_slot.start};
    end else begin
      wr_slot = '{session: sid, count: CountW'(1), start: seconds_now};
    end
  end

  ser_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  // Sequencer, valid bits and seconds counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issue_cnt    <= '0;
      chk_vld      <= 1'b0;
      result_valid <= 1'b0;
      slot_valid   <= '0;
      seconds_now  <= '0;
    end else begin
      result_valid <= 1'b0;
      chk_vld      <= rd_en;
      chk_idx      <= rd_addr;
      if (rd_en) begin
        issue_cnt <= issue_cnt + CntW'(1);
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            sid        <= cmd.session_id;
            issue_cnt  <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (cmd.kind == KIND_TICK) begin
              seconds_now <= seconds_now + StampW'(1);
            end
            if (cfg.enable) begin
              state <= (cmd.kind == KIND_TICK) ? ST_SWEEP : ST_SCAN;
            end else begin
              result_valid <= 1'b1;
              result       <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (chk_vld) begin
            if (slot_valid[chk_idx] && (rd_slot.session == sid) && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_idx;
              hit_slot  <= rd_slot;
            end
            if (!slot_valid[chk_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (chk_idx == LastIdx) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_SWEEP: begin
          if (chk_vld) begin
            if (slot_valid[chk_idx] && (age >= {16'b0, cfg.window_seconds})) begin
              slot_valid[chk_idx] <= 1'b0;
            end
            if (chk_idx == LastIdx) begin
              result_valid <= 1'b1;
              result       <= '0;
              state        <= ST_IDLE;
            end
          end
        end
        ST_UPDATE: begin
          result_valid <= 1'b1;
          result       <= '0;
          if (hit_found) begin
            if (eject_hit) begin
              slot_valid[hit_idx]  <= 1'b0;
              result.eject         <= 1'b1;
              result.eject_session <= hit_slot.session;
              result.eject_seconds <= eject_secs;
            end
          end else if (free_found) begin
            slot_valid[free_idx] <= 1'b1;
          end else begin
            result.table_full <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result only follows a cycle of work or an accepted item.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) != ST_IDLE) || $past(start))
    else $error("result without a preceding item");

  // An enabled entry item always starts a table scan.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.kind == KIND_ENTRY) && cfg.enable) |=> (state == ST_SCAN))
    else $error("entry item did not start a scan");

  // Read data is only checked while the table is being walked.
  assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> ((state == ST_SCAN) || (state == ST_SWEEP)))
    else $error("table read outside a walk");

  // A result never reports an ejection and a full table at once.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.eject && result.table_full))
    else $error("eject and table_full both set");
`endif

endmodule

// ===== sv/session_entry_rate_limiter.sv =====
// Top level of the session entry rate limiter: configuration registers and table engine.
`timescale 1ns / 1ps

// Fixed-window session entry rate limiter. An item is accepted when start is high and
// busy is low; its single result appears on result for one cycle with result_valid high,
// and the receiver must take it then. An entry item walks the whole session table in
// memory one slot per cycle and then writes back; a tick item walks it for its expiry
// sweep. While enable is clear, every item returns an all-zero result in the cycle
// after acceptance. The table walk goes through the single read port of the slot
// memory. Configuration writes are always ready and must only be made while the block
// is idle.
module session_entry_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = ser_pkg::TableEntriesDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ser_pkg::in_item_t                  cmd,
  output logic                               result_valid,
  output ser_pkg::out_item_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ser_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [ser_pkg::CfgDataW-1:0]       cfg_data
);

  import ser_pkg::*;

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.max_entries    <= MaxEntriesReset;
      cfg.window_seconds <= WindowReset;
      cfg.eject_minutes  <= EjectMinutesReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENABLE:      cfg.enable         <= cfg_data[0];
        CFG_MAX_ENTRIES: cfg.max_entries    <= cfg_data[7:0];
        CFG_WINDOW:      cfg.window_seconds <= cfg_data[15:0];
        CFG_EJECT_MIN:   cfg.eject_minutes  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  ser_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
